### rtl/core/distance_constraint_solve_unit_macros.svh
// Assertion macros for the distance constraint solve unit checker.
// Expects signals named clk and arst_n in the scope that uses them.
`ifndef DISTANCE_CONSTRAINT_SOLVE_UNIT_MACROS_SVH
`define DISTANCE_CONSTRAINT_SOLVE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/dcs_pkg.sv
// Shared types and constants for the distance constraint solve unit.
// No dependencies; imported by every module of the block.
package dcs_pkg;

	localparam int POS_W   = 24;
	localparam int MASS_W  = 16;
	localparam int STIFF_W = 17;
	localparam int MAG_W   = POS_W + 1;
	localparam int RAD_W   = 64;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int ERR_W   = 34;
	localparam int UNIT_W  = 25;
	localparam int UNUM_W  = 55;
	localparam int SNUM_W  = STIFF_W + MASS_W;
	localparam int SUM_W   = MASS_W + 1;
	localparam int PROD_W  = STIFF_W + UNIT_W;
	localparam int T_W     = PROD_W + 1 - 16;
	localparam int CPROD_W = T_W + ERR_W;
	localparam int CORR_W  = CPROD_W + 1 - 30;
	localparam int SQ_SHIFT   = 14;
	localparam int REST_SHIFT = 7;
	localparam int UNIT_SHIFT = 30;

	localparam logic [STIFF_W-1:0] ONE_Q16 = STIFF_W'(65536);
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	typedef struct packed {
		logic signed [POS_W-1:0] p1_x;
		logic signed [POS_W-1:0] p1_y;
		logic signed [POS_W-1:0] p2_x;
		logic signed [POS_W-1:0] p2_y;
		logic [MASS_W-1:0]       p1_mass;
		logic [MASS_W-1:0]       p2_mass;
		logic [POS_W-1:0]        rest_length;
	} req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] new_p1_x;
		logic signed [POS_W-1:0] new_p1_y;
		logic signed [POS_W-1:0] new_p2_x;
		logic signed [POS_W-1:0] new_p2_y;
		logic                    degenerate;
		logic                    saturated;
	} rsp_t;

endpackage

### rtl/core/dcs_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
// Depends on dcs_pkg for the radicand and root widths.
module dcs_sqrt import dcs_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [RAD_W-1:0]  in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);

	logic              vld_s  [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [RAD_W-1:0]  root_s [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
		logic              v_in;
		logic [RAD_W-1:0]  rad_in;
		logic [RAD_W-1:0]  root_in;
		logic [SIDE_W-1:0] sd_in;
		logic [RAD_W:0]    trial;
		logic              take;

		if (k == 0) begin : g_first
			assign v_in    = in_vld;
			assign rad_in  = in_rad;
			assign root_in = '0;
			assign sd_in   = in_side;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign root_in = root_s[k-1];
			assign sd_in   = side_s[k-1];
		end

		assign trial = {1'b0, root_in} + {1'b0, BIT};
		assign take  = {1'b0, rad_in} >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= take ? rad_in - trial[RAD_W-1:0] : rad_in;
				root_s[k] <= take ? (root_in >> 1) + BIT : root_in >> 1;
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_vld  = vld_s[ROOT_W-1];
	assign out_root = root_s[ROOT_W-1][ROOT_W-1:0];
	assign out_side = side_s[ROOT_W-1];

endmodule

### rtl/core/dcs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
// Depends on dcs_pkg only through the common import convention.
module dcs_div import dcs_pkg::*; #(
	parameter int NW     = 55,
	parameter int DW     = 32,
	parameter int QW     = 25,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NW-1:0]     in_num,
	input  logic [DW-1:0]     in_den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_vld,
	output logic [QW-1:0]     out_quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int WW = ((NW > DW + QW) ? NW : DW + QW) + 1;

	logic              vld_s  [QW];
	logic [NW-1:0]     rem_s  [QW];
	logic [DW-1:0]     den_s  [QW];
	logic [QW-1:0]     quo_s  [QW];
	logic [SIDE_W-1:0] side_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int SH = QW - 1 - k;
		logic              v_in;
		logic [NW-1:0]     rem_in;
		logic [DW-1:0]     den_in;
		logic [QW-1:0]     quo_in;
		logic [SIDE_W-1:0] sd_in;
		logic [WW-1:0]     dsh;
		logic              take;

		if (k == 0) begin : g_first
			assign v_in   = in_vld;
			assign rem_in = in_num;
			assign den_in = in_den;
			assign quo_in = '0;
			assign sd_in  = in_side;
		end else begin : g_next
			assign v_in   = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign den_in = den_s[k-1];
			assign quo_in = quo_s[k-1];
			assign sd_in  = side_s[k-1];
		end

		assign dsh  = WW'(den_in) << SH;
		assign take = WW'(rem_in) >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? NW'(WW'(rem_in) - dsh) : rem_in;
				den_s[k]  <= den_in;
				quo_s[k]  <= quo_in | (QW'(take) << SH);
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign out_quo  = quo_s[QW-1];
	assign out_side = side_s[QW-1];

endmodule

### rtl/core/distance_constraint_solve_unit.sv
// Top level of the distance constraint solve unit: one link projected per request.
// Depends on dcs_pkg, dcs_sqrt and dcs_div.
//
//   channel   | handshake              | payload
//   ----------+------------------------+--------------------------
//   request   | req_valid / req_stall  | req (req_t)
//   response  | rsp_valid / rsp_stall  | rsp (rsp_t)
//   config    | stiff_we               | stiff_wdata (17 bits)
//
// One request enters per cycle unless a stalled response holds the pipeline.
// The pipeline runs through the 32-stage square root and the 25-stage divider.
// Reset clears all valid bits and sets the stiffness to 1.0; there is no clearing pass.
// A stalled response freezes the whole pipeline, and req_stall follows it.
module distance_constraint_solve_unit import dcs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               stiff_we,
	input  logic [STIFF_W-1:0] stiff_wdata,
	input  logic               req_valid,
	output logic               req_stall,
	input  req_t               req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output rsp_t               rsp
);

	typedef struct packed {
		req_t               req;
		logic               xneg;
		logic               yneg;
		logic               degen;
		logic [SNUM_W-1:0]  snum;
		logic [SUM_W-1:0]   msum;
		logic [STIFF_W-1:0] st;
		logic [MAG_W-1:0]   ax;
		logic [MAG_W-1:0]   ay;
	} root_side_t;

	typedef struct packed {
		req_t               req;
		logic               nx;
		logic               ny;
		logic               degen;
		logic [STIFF_W-1:0] st;
		logic [SUM_W-1:0]   msum;
		logic [ERR_W-1:0]   emag;
	} div_side_t;

	typedef struct packed {
		req_t             req;
		logic             nx;
		logic             ny;
		logic             degen;
		logic [ERR_W-1:0] emag;
	} tail_t;

	logic [STIFF_W-1:0] stiff_q;
	logic [STIFF_W-1:0] st_eff;
	logic               en;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= ONE_Q16;
		end else if (stiff_we) begin
			stiff_q <= stiff_wdata;
		end
	end

	assign st_eff    = (stiff_q > ONE_Q16) ? ONE_Q16 : stiff_q;
	assign en        = !rsp_valid_q || !rsp_stall;
	assign req_stall = !en;

	// Stage 1: differences, mass sum and stiffness times the far mass.
	logic                    v_s1;
	req_t                    req_s1;
	logic signed [MAG_W-1:0] dx_s1, dy_s1;
	logic [SNUM_W-1:0]       stm_s1;
	logic [SUM_W-1:0]        msum_s1;
	logic [STIFF_W-1:0]      st_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1  <= req;
			dx_s1   <= MAG_W'(req.p1_x) - MAG_W'(req.p2_x);
			dy_s1   <= MAG_W'(req.p1_y) - MAG_W'(req.p2_y);
			stm_s1  <= SNUM_W'(st_eff) * SNUM_W'(req.p2_mass);
			msum_s1 <= SUM_W'(req.p1_mass) + SUM_W'(req.p2_mass);
			st_s1   <= st_eff;
		end
	end

	// Stage 2: magnitudes and the rounded mass-split numerator.
	logic               v_s2;
	root_side_t         side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.req   <= req_s1;
			side_s2.xneg  <= dx_s1[MAG_W-1];
			side_s2.yneg  <= dy_s1[MAG_W-1];
			side_s2.degen <= (dx_s1 == '0) && (dy_s1 == '0);
			side_s2.snum  <= stm_s1 + SNUM_W'(msum_s1 >> 1);
			side_s2.msum  <= msum_s1;
			side_s2.st    <= st_s1;
			side_s2.ax    <= dx_s1[MAG_W-1] ? MAG_W'(-dx_s1) : MAG_W'(dx_s1);
			side_s2.ay    <= dy_s1[MAG_W-1] ? MAG_W'(-dy_s1) : MAG_W'(dy_s1);
		end
	end

	// Stage 3: squared length, scaled so the root carries 7 extra fraction bits.
	logic               v_s3;
	root_side_t         side_s3;
	logic [RAD_W-1:0]   rad_s3;
	logic [2*MAG_W-1:0] sqx, sqy;

	assign sqx = side_s2.ax * side_s2.ax;
	assign sqy = side_s2.ay * side_s2.ay;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= side_s2;
			rad_s3  <= (RAD_W'(sqx) + RAD_W'(sqy)) << SQ_SHIFT;
		end
	end

	logic               v_rt;
	logic [ROOT_W-1:0]  root_rt;
	logic [$bits(root_side_t)-1:0] side_rt_raw;
	root_side_t         side_rt;

	dcs_sqrt #(
		.SIDE_W($bits(root_side_t))
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (v_s3),
		.in_rad  (rad_s3),
		.in_side (side_s3),
		.out_vld (v_rt),
		.out_root(root_rt),
		.out_side(side_rt_raw)
	);

	assign side_rt = root_side_t'(side_rt_raw);

	// Stage 4: length error, unit-vector numerators and divider operands.
	logic                    v_s4;
	logic [UNUM_W-1:0]       unx_s4, uny_s4;
	logic [ROOT_W-1:0]       root_s4;
	logic [SNUM_W-1:0]       snum_s4;
	logic [SUM_W-1:0]        msum_s4;
	div_side_t               dside_s4;
	logic signed [ERR_W-1:0] err;
	logic                    eneg;

	assign err  = ERR_W'({side_rt.req.rest_length, REST_SHIFT'(0)}) - ERR_W'(root_rt);
	assign eneg = err[ERR_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			unx_s4         <= (UNUM_W'(side_rt.ax) << UNIT_SHIFT) + UNUM_W'(root_rt >> 1);
			uny_s4         <= (UNUM_W'(side_rt.ay) << UNIT_SHIFT) + UNUM_W'(root_rt >> 1);
			root_s4        <= root_rt;
			snum_s4        <= side_rt.snum;
			msum_s4        <= side_rt.msum;
			dside_s4.req   <= side_rt.req;
			dside_s4.nx    <= side_rt.xneg ^ eneg;
			dside_s4.ny    <= side_rt.yneg ^ eneg;
			dside_s4.degen <= side_rt.degen;
			dside_s4.st    <= side_rt.st;
			dside_s4.msum  <= side_rt.msum;
			dside_s4.emag  <= eneg ? ERR_W'(-err) : ERR_W'(err);
		end
	end

	logic                          v_dv;
	logic [UNIT_W-1:0]             ux_dv, uy_dv;
	logic [UNIT_W-1:0]             sq_dv;
	logic [$bits(div_side_t)-1:0]  dside_raw;
	div_side_t                     dside_dv;

	dcs_div #(
		.NW(UNUM_W), .DW(ROOT_W), .QW(UNIT_W), .SIDE_W($bits(div_side_t))
	) u_div_x (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(v_s4), .in_num(unx_s4), .in_den(root_s4), .in_side(dside_s4),
		.out_vld(v_dv), .out_quo(ux_dv), .out_side(dside_raw)
	);

	dcs_div #(
		.NW(UNUM_W), .DW(ROOT_W), .QW(UNIT_W), .SIDE_W(1)
	) u_div_y (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(v_s4), .in_num(uny_s4), .in_den(root_s4), .in_side(1'b0),
		.out_vld(), .out_quo(uy_dv), .out_side()
	);

	// The share never exceeds the stiffness, so its upper quotient bits stay zero;
	// the divider is as deep as the unit-vector dividers so the results line up.
	dcs_div #(
		.NW(SNUM_W), .DW(SUM_W), .QW(UNIT_W), .SIDE_W(1)
	) u_div_s (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_vld(v_s4), .in_num(snum_s4), .in_den(msum_s4), .in_side(1'b0),
		.out_vld(), .out_quo(sq_dv), .out_side()
	);

	assign dside_dv = div_side_t'(dside_raw);

	// Stage 5: stiffness share of each point.
	logic               v_s5;
	logic [STIFF_W-1:0] s1_s5, s2_s5;
	logic [UNIT_W-1:0]  ux_s5, uy_s5;
	tail_t              tail_s5;
	logic [STIFF_W-1:0] s1_pick;

	// Both masses zero: split evenly, rounding down.
	assign s1_pick = (dside_dv.msum == '0) ? (dside_dv.st >> 1) : sq_dv[STIFF_W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			s1_s5         <= s1_pick;
			s2_s5         <= dside_dv.st - s1_pick;
			ux_s5         <= ux_dv;
			uy_s5         <= uy_dv;
			tail_s5.req   <= dside_dv.req;
			tail_s5.nx    <= dside_dv.nx;
			tail_s5.ny    <= dside_dv.ny;
			tail_s5.degen <= dside_dv.degen;
			tail_s5.emag  <= dside_dv.emag;
		end
	end

	// Stage 6: share times unit component.
	logic              v_s6;
	logic [PROD_W-1:0] p1x_s6, p1y_s6, p2x_s6, p2y_s6;
	tail_t             tail_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			p1x_s6  <= PROD_W'(s1_s5) * PROD_W'(ux_s5);
			p1y_s6  <= PROD_W'(s1_s5) * PROD_W'(uy_s5);
			p2x_s6  <= PROD_W'(s2_s5) * PROD_W'(ux_s5);
			p2y_s6  <= PROD_W'(s2_s5) * PROD_W'(uy_s5);
			tail_s6 <= tail_s5;
		end
	end

	// Stage 7: round to the step factor.
	logic           v_s7;
	logic [T_W-1:0] t1x_s7, t1y_s7, t2x_s7, t2y_s7;
	tail_t          tail_s7;

	function automatic logic [T_W-1:0] round_t(input logic [PROD_W-1:0] p);
		logic [PROD_W:0] s;
		s = {1'b0, p} + (PROD_W+1)'(1 << 15);
		return s[PROD_W:16];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			t1x_s7  <= round_t(p1x_s6);
			t1y_s7  <= round_t(p1y_s6);
			t2x_s7  <= round_t(p2x_s6);
			t2y_s7  <= round_t(p2y_s6);
			tail_s7 <= tail_s6;
		end
	end

	// Stage 8: step factor times error magnitude.
	logic               v_s8;
	logic [CPROD_W-1:0] c1x_s8, c1y_s8, c2x_s8, c2y_s8;
	tail_t              tail_s8;

	always_ff @(posedge clk) begin
		if (en) begin
			c1x_s8  <= CPROD_W'(t1x_s7) * CPROD_W'(tail_s7.emag);
			c1y_s8  <= CPROD_W'(t1y_s7) * CPROD_W'(tail_s7.emag);
			c2x_s8  <= CPROD_W'(t2x_s7) * CPROD_W'(tail_s7.emag);
			c2y_s8  <= CPROD_W'(t2y_s7) * CPROD_W'(tail_s7.emag);
			tail_s8 <= tail_s7;
		end
	end

	// Stage 9: round, apply with sign, clamp into the output register.
	function automatic logic signed [POS_W+1:0] apply_corr(
		input logic signed [POS_W-1:0] p,
		input logic [CPROD_W-1:0]      cp,
		input logic                    sub
	);
		logic [CPROD_W:0]           s;
		logic signed [CORR_W+1:0]   base;
		logic signed [CORR_W+1:0]   cv;
		logic signed [CORR_W+1:0]   r;
		s    = {1'b0, cp} + (CPROD_W+1)'(1 << 29);
		base = (CORR_W+2)'(p);
		cv   = (CORR_W+2)'({1'b0, s[CPROD_W:30]});
		r    = sub ? base - cv : base + cv;
		if (r > (CORR_W+2)'(POS_MAX)) begin
			return {1'b1, 1'b0, POS_MAX};
		end else if (r < (CORR_W+2)'(POS_MIN)) begin
			return {1'b1, 1'b1, POS_MIN};
		end
		return {1'b0, r[POS_W-1:0]};
	endfunction

	logic signed [POS_W+1:0] r1x, r1y, r2x, r2y;

	assign r1x = apply_corr(tail_s8.req.p1_x, c1x_s8, tail_s8.nx);
	assign r1y = apply_corr(tail_s8.req.p1_y, c1y_s8, tail_s8.ny);
	assign r2x = apply_corr(tail_s8.req.p2_x, c2x_s8, !tail_s8.nx);
	assign r2y = apply_corr(tail_s8.req.p2_y, c2y_s8, !tail_s8.ny);

	always_ff @(posedge clk) begin
		if (en) begin
			if (tail_s8.degen) begin
				rsp_q.new_p1_x   <= tail_s8.req.p1_x;
				rsp_q.new_p1_y   <= tail_s8.req.p1_y;
				rsp_q.new_p2_x   <= tail_s8.req.p2_x;
				rsp_q.new_p2_y   <= tail_s8.req.p2_y;
				rsp_q.degenerate <= 1'b1;
				rsp_q.saturated  <= 1'b0;
			end else begin
				rsp_q.new_p1_x   <= r1x[POS_W-1:0];
				rsp_q.new_p1_y   <= r1y[POS_W-1:0];
				rsp_q.new_p2_x   <= r2x[POS_W-1:0];
				rsp_q.new_p2_y   <= r2y[POS_W-1:0];
				rsp_q.degenerate <= 1'b0;
				rsp_q.saturated  <= r1x[POS_W+1] | r1y[POS_W+1] | r2x[POS_W+1] | r2y[POS_W+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= req_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_rt;
			v_s5        <= v_dv;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			rsp_valid_q <= v_s8;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

### rtl/core/dcs_chk.sv
// Port-level checker for the distance constraint solve unit, bound to the top level.
// Depends on dcs_pkg and distance_constraint_solve_unit_macros.svh.
`include "distance_constraint_solve_unit_macros.svh"

module dcs_chk import dcs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	logic at_rail;

	assign at_rail = (rsp.new_p1_x == POS_MAX) || (rsp.new_p1_x == POS_MIN) ||
		(rsp.new_p1_y == POS_MAX) || (rsp.new_p1_y == POS_MIN) ||
		(rsp.new_p2_x == POS_MAX) || (rsp.new_p2_x == POS_MIN) ||
		(rsp.new_p2_y == POS_MAX) || (rsp.new_p2_y == POS_MIN);

	`DCS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
	`DCS_ASSERT_NOW(a_req_stall, req_stall, rsp_valid && rsp_stall, "request stalled without a stalled response")
	`DCS_ASSERT_NOW(a_degen_nosat, rsp_valid && rsp.degenerate, !rsp.saturated, "degenerate link flagged saturated")
	`DCS_ASSERT_NOW(a_sat_rail, rsp_valid && rsp.saturated, at_rail, "saturated without a clamped coordinate")

endmodule

bind distance_constraint_solve_unit dcs_chk u_dcs_chk (.*);
